FILE: hdl/lfxr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfxr_pkg
// Shared types and constants for the length-framed XOR checksum receiver.
// ----------------------------------------------------------------------------
package lfxr_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned XOR_W       = 32;
    localparam int unsigned SUFFIX_W    = 2;
    localparam int unsigned TDATA_W     = 32;
    localparam logic [2:0]  CHECK_BYTES = 3'd4;
    localparam logic [SUFFIX_W-1:0] SUFFIX_RESET = 2'd2;

    typedef enum logic [2:0] {
        PH_LEN_HI  = 3'd0,
        PH_LEN_LO  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CHECK   = 3'd3,
        PH_TRAILER = 3'd4
    } t_phase;

    typedef struct packed {
        logic [LEN_W-1:0]  frame_length;
        logic              checksum_ok;
        logic [BYTE_W-1:0] out_byte;
        logic              kind;
        logic              last;
    } t_result;

endpackage

FILE: hdl/lfxr_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfxr_parse
// Frame parser: tracks the frame section, folds bytes into the XOR lanes and
// forms one result item per processed byte when the byte produces one.
// ----------------------------------------------------------------------------
module lfxr_parse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lfxr_pkg::SUFFIX_W-1:0] i_cfg_data,
    input  logic                          i_valid,
    input  logic [lfxr_pkg::BYTE_W-1:0]   i_byte,
    output logic                          o_res_valid,
    output lfxr_pkg::t_result             o_res
);

    lfxr_pkg::t_phase                  r_phase, n_phase;
    logic [lfxr_pkg::LEN_W-1:0]        r_len, n_len;
    logic [lfxr_pkg::LEN_W-1:0]        r_pos, n_pos;
    logic [lfxr_pkg::XOR_W-1:0]        r_xor, n_xor;
    logic [lfxr_pkg::SUFFIX_W-1:0]     r_suffix;
    logic [lfxr_pkg::LEN_W-1:0]        pos_inc;
    logic [lfxr_pkg::XOR_W-1:0]        folded;

    assign pos_inc = r_pos + 16'd1;

    // Byte lane 0 sits in the top bits of the running XOR.
    always_comb begin
        folded = r_xor;
        case (r_pos[1:0])
            2'd0:    folded[31:24] = r_xor[31:24] ^ i_byte;
            2'd1:    folded[23:16] = r_xor[23:16] ^ i_byte;
            2'd2:    folded[15:8]  = r_xor[15:8]  ^ i_byte;
            default: folded[7:0]   = r_xor[7:0]   ^ i_byte;
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_pos       = r_pos;
        n_xor       = r_xor;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_valid) begin
            case (r_phase)
                lfxr_pkg::PH_LEN_LO: begin
                    n_len   = {r_len[15:8], i_byte};
                    n_pos   = '0;
                    n_xor   = '0;
                    n_phase = ({r_len[15:8], i_byte} == 16'd0) ?
                              lfxr_pkg::PH_CHECK : lfxr_pkg::PH_PAYLOAD;
                end
                lfxr_pkg::PH_PAYLOAD: begin
                    n_xor          = folded;
                    n_pos          = pos_inc;
                    o_res_valid    = 1'b1;
                    o_res.out_byte = i_byte;
                    if (pos_inc >= r_len) begin
                        o_res.last = 1'b1;
                        n_pos      = '0;
                        n_phase    = lfxr_pkg::PH_CHECK;
                    end
                end
                lfxr_pkg::PH_CHECK: begin
                    n_xor = folded;
                    n_pos = pos_inc;
                    if (pos_inc >= {13'd0, lfxr_pkg::CHECK_BYTES}) begin
                        n_pos   = '0;
                        n_phase = lfxr_pkg::PH_TRAILER;
                        if (r_suffix == '0) begin
                            o_res_valid        = 1'b1;
                            o_res.kind         = 1'b1;
                            o_res.checksum_ok  = (folded == '0);
                            o_res.frame_length = r_len;
                            n_phase            = lfxr_pkg::PH_LEN_HI;
                            n_xor              = '0;
                        end
                    end
                end
                lfxr_pkg::PH_TRAILER: begin
                    n_pos = pos_inc;
                    if (pos_inc >= {14'd0, r_suffix}) begin
                        o_res_valid        = 1'b1;
                        o_res.kind         = 1'b1;
                        o_res.checksum_ok  = (r_xor == '0);
                        o_res.frame_length = r_len;
                        n_phase            = lfxr_pkg::PH_LEN_HI;
                        n_pos              = '0;
                        n_xor              = '0;
                    end
                end
                default: begin
                    n_len   = {i_byte, 8'd0};
                    n_pos   = '0;
                    n_xor   = '0;
                    n_phase = lfxr_pkg::PH_LEN_LO;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= lfxr_pkg::PH_LEN_HI;
            r_len    <= '0;
            r_pos    <= '0;
            r_xor    <= '0;
            r_suffix <= lfxr_pkg::SUFFIX_RESET;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_xor   <= n_xor;
            if (i_cfg_we) begin
                r_suffix <= i_cfg_data;
            end
        end
    end

endmodule

FILE: hdl/lfxr_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfxr_obuf
// Two-entry result buffer; its full flag is registered so the downstream
// ready never reaches the input side combinationally.
// ----------------------------------------------------------------------------
module lfxr_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  lfxr_pkg::t_result i_res,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output lfxr_pkg::t_result o_res
);

    lfxr_pkg::t_result r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count, n_count;
    logic              rd;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign rd      = o_valid && i_ready;
    assign o_res   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_wr && !rd) begin
            n_count = r_count + 2'd1;
        end else if (rd && !i_wr) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

endmodule

FILE: hdl/length_framed_xor_checksum_receiver.sv
`timescale 1ns / 1ps
// Path: an accepted byte is held in the input register and processed by the
// parser while the output buffer is not full; its result goes into that buffer.
// Throughput: one byte per cycle, one parser pass each, unless buffer is full.
// Reset: i_rst_n is synchronous, active low; the parser returns to the length
// high byte, the suffix register to 2, and both buffers are emptied.
// ----------------------------------------------------------------------------
// length_framed_xor_checksum_receiver
// Receives length-framed bytes, forwards payload and reports checksum status.
// ----------------------------------------------------------------------------
module length_framed_xor_checksum_receiver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lfxr_pkg::SUFFIX_W-1:0] i_cfg_data,   // suffix_bytes
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lfxr_pkg::BYTE_W-1:0]   s_axis_tdata, // [7:0] rx_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] out_byte, [8] checksum_ok, [24:9] frame_length, [31:25] zero
    output logic [lfxr_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tuser, // [0] kind
    output logic                          m_axis_tlast  // last
);

    logic                        r_in_valid;
    logic [lfxr_pkg::BYTE_W-1:0] r_in_byte;
    logic                        advance;
    logic                        buf_full;
    logic                        res_valid;
    lfxr_pkg::t_result           res;
    lfxr_pkg::t_result           out_res;

    assign o_cfg_ready   = 1'b1;
    assign advance       = r_in_valid && !buf_full;
    assign s_axis_tready = !r_in_valid || !buf_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    lfxr_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (advance),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lfxr_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_res   (res),
        .o_full  (buf_full),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {7'd0, out_res.frame_length, out_res.checksum_ok, out_res.out_byte};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule
